[rtl/core/pta_pkg.sv]
// Shared types and constants for the tile-average pixelation block.
// Used by the controller, the datapath and the top level.
package pta_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int MaxBlock  = 64;

    localparam int DimW   = 11;                   // register width for width/height
    localparam int BlkW   = 7;                    // register width for block size
    localparam int PosW   = $clog2(MaxWidth);     // column / row position
    localparam int OffW   = $clog2(MaxBlock);     // offset inside a tile
    localparam int SumW   = 20;
    localparam int CntW   = 13;

    localparam int WordW  = 3 * SumW + CntW;

    localparam logic [1:0] RegBlockSize   = 2'd0;
    localparam logic [1:0] RegImageWidth  = 2'd1;
    localparam logic [1:0] RegImageHeight = 2'd2;

    localparam logic [BlkW-1:0] ResetBlock  = 7'd20;
    localparam logic [DimW-1:0] ResetWidth  = 11'd640;
    localparam logic [DimW-1:0] ResetHeight = 11'd480;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;   // accept pixel, launch column read
        logic accum;     // add pixel, write back, advance position
        logic div_step;  // one quotient bit of the three dividers
        logic load_out;  // move finished tile into the output register
    } t_cmd;

    typedef struct packed {
        logic tile_end;  // current pixel closes a tile
        logic div_done;  // last quotient bit this cycle
    } t_status;

endpackage

[rtl/core/pta_ctrl.sv]
// Controller state machine of the tile-average block.
// Depends on pta_pkg for the state and command types.
module pta_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  pta_pkg::t_status i_status,
    output pta_pkg::t_cmd    o_cmd
);
    import pta_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register: filled by load_out, emptied by an output transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_ACC;
            S_ACC:  n_state = i_status.tile_end ? S_DIV : S_IDLE;
            S_DIV:  if (i_status.div_done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = (r_state == S_IDLE);
        o_valid        = r_out_valid;
        o_cmd.capture  = (r_state == S_IDLE) && i_valid;
        o_cmd.accum    = (r_state == S_ACC);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.load_out = (r_state == S_OUT) && out_free;
    end

endmodule

[rtl/core/pta_datapath.sv]
// Datapath: configuration, raster counters, per-column sum memory and
// three shift-subtract dividers. Depends on pta_pkg.
module pta_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [1:0]               i_cfg_index,
    input  logic [10:0]              i_cfg_data,
    input  logic [7:0]               i_red,
    input  logic [7:0]               i_green,
    input  logic [7:0]               i_blue,
    input  pta_pkg::t_cmd            i_cmd,
    output pta_pkg::t_status         o_status,
    output logic [9:0]               o_tile_column,
    output logic [9:0]               o_tile_row,
    output logic [7:0]               o_avg_red,
    output logic [7:0]               o_avg_green,
    output logic [7:0]               o_avg_blue,
    output logic                     o_last_tile
);
    import pta_pkg::*;

    logic [BlkW-1:0] r_block;
    logic [DimW-1:0] r_width, r_height;
    logic [BlkW-1:0] b_eff;
    logic [DimW-1:0] w_eff, h_eff;
    logic [OffW-1:0] b_last;
    logic [PosW-1:0] w_last, h_last;

    logic [PosW-1:0] r_x, r_y, r_tc, r_tr;
    logic [OffW-1:0] r_ox, r_oy;
    logic [PosW:0]   r_fill;   // tile columns touched since frame restart

    logic [WordW-1:0] mem [MaxWidth];
    logic [WordW-1:0] r_rd;
    logic [7:0]       r_pr, r_pg, r_pb;

    logic [SumW-1:0] rd_r, rd_g, rd_b, sum_r, sum_g, sum_b;
    logic [CntW-1:0] rd_c, sum_c;
    logic            entry_ok, end_x, end_y, restart;

    logic [SumW-1:0] r_rem_r, r_rem_g, r_rem_b;
    logic [CntW-1:0] r_div;
    logic [2:0]      r_step;
    logic [7:0]      r_q_r, r_q_g, r_q_b;
    logic [SumW:0]   dvs, t_r, t_g, t_b;
    logic [PosW-1:0] r_hold_tc, r_hold_tr;
    logic            r_hold_last;

    // effective register values
    always_comb begin
        if (r_block == '0)             b_eff = BlkW'(1);
        else if (r_block > BlkW'(MaxBlock)) b_eff = BlkW'(MaxBlock);
        else                           b_eff = r_block;
        if (r_width == '0)             w_eff = DimW'(1);
        else if (r_width > DimW'(MaxWidth)) w_eff = DimW'(MaxWidth);
        else                           w_eff = r_width;
        if (r_height == '0)            h_eff = DimW'(1);
        else if (r_height > DimW'(MaxHeight)) h_eff = DimW'(MaxHeight);
        else                           h_eff = r_height;
        b_last = OffW'(b_eff - BlkW'(1));
        w_last = PosW'(w_eff - DimW'(1));
        h_last = PosW'(h_eff - DimW'(1));
    end

    assign restart = i_cfg_valid && (i_cfg_index == RegBlockSize ||
                                     i_cfg_index == RegImageWidth ||
                                     i_cfg_index == RegImageHeight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block  <= ResetBlock;
            r_width  <= ResetWidth;
            r_height <= ResetHeight;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegBlockSize:   r_block  <= i_cfg_data[BlkW-1:0];
                RegImageWidth:  r_width  <= i_cfg_data;
                RegImageHeight: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // unpack column entry; entries past the fill mark are stale from an earlier frame
    always_comb begin
        entry_ok = ({1'b0, r_tc} < r_fill);
        {rd_r, rd_g, rd_b, rd_c} = entry_ok ? r_rd : '0;
        sum_r = rd_r + SumW'(r_pr);
        sum_g = rd_g + SumW'(r_pg);
        sum_b = rd_b + SumW'(r_pb);
        sum_c = rd_c + CntW'(1);
        end_x = (r_ox == b_last) || (r_x == w_last);
        end_y = (r_oy == b_last) || (r_y == h_last);
        o_status.tile_end = end_x && end_y;
        o_status.div_done = (r_step == 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd <= mem[r_tc];
            r_pr <= i_red;
            r_pg <= i_green;
            r_pb <= i_blue;
        end
        if (i_cmd.accum) begin
            mem[r_tc] <= o_status.tile_end ? '0 : {sum_r, sum_g, sum_b, sum_c};
        end
    end

    // raster position and tile indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_x    <= '0;
            r_y    <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_tc   <= '0;
            r_tr   <= '0;
            r_fill <= '0;
        end else if (i_cmd.accum) begin
            if ({1'b0, r_tc} == r_fill) r_fill <= r_fill + 1'b1;
            if (r_x == w_last) begin
                r_x  <= '0;
                r_ox <= '0;
                r_tc <= '0;
                if (r_y == h_last) begin
                    r_y  <= '0;
                    r_oy <= '0;
                    r_tr <= '0;
                end else begin
                    r_y <= r_y + 1'b1;
                    if (r_oy == b_last) begin
                        r_oy <= '0;
                        r_tr <= r_tr + 1'b1;
                    end else begin
                        r_oy <= r_oy + 1'b1;
                    end
                end
            end else begin
                r_x <= r_x + 1'b1;
                if (r_ox == b_last) begin
                    r_ox <= '0;
                    r_tc <= r_tc + 1'b1;
                end else begin
                    r_ox <= r_ox + 1'b1;
                end
            end
        end
    end

    // restoring division, quotient known to fit 8 bits, MSB first
    always_comb begin
        dvs = (SumW+1)'(r_div) << r_step;
        t_r = {1'b0, r_rem_r} - dvs;
        t_g = {1'b0, r_rem_g} - dvs;
        t_b = {1'b0, r_rem_b} - dvs;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && o_status.tile_end) begin
            r_rem_r     <= sum_r;
            r_rem_g     <= sum_g;
            r_rem_b     <= sum_b;
            r_div       <= sum_c;
            r_step      <= 3'd7;
            r_hold_tc   <= r_tc;
            r_hold_tr   <= r_tr;
            r_hold_last <= (r_x == w_last) && (r_y == h_last);
        end else if (i_cmd.div_step) begin
            if (!t_r[SumW]) r_rem_r <= t_r[SumW-1:0];
            if (!t_g[SumW]) r_rem_g <= t_g[SumW-1:0];
            if (!t_b[SumW]) r_rem_b <= t_b[SumW-1:0];
            r_q_r  <= {r_q_r[6:0], ~t_r[SumW]};
            r_q_g  <= {r_q_g[6:0], ~t_g[SumW]};
            r_q_b  <= {r_q_b[6:0], ~t_b[SumW]};
            r_step <= r_step - 3'd1;
        end
    end

    // output register, frees the divider for the next tile
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_tile_column <= r_hold_tc;
            o_tile_row    <= r_hold_tr;
            o_last_tile   <= r_hold_last;
            o_avg_red     <= r_q_r;
            o_avg_green   <= r_q_g;
            o_avg_blue    <= r_q_b;
        end
    end

endmodule

[rtl/core/pixelate_tile_average.sv]
// Mosaic pixelation: each pixel goes through the column-sum memory read followed
// by the read-modify-write, and the next pixel is not taken before that is done;
// a pixel that closes a tile then runs shift-subtract division (one quotient bit per
// cycle for the three colors at once) and a step that moves the tile into the output register.
// Pixels keep flowing while that register waits to be taken; the input stalls
// during the division, and also when a second tile finishes before the first
// has left. No clearing pass is needed after reset or a configuration write.
// Top level; depends on pta_pkg, pta_ctrl and pta_datapath.
module pixelate_tile_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_tile_column,
    output logic [9:0]  o_tile_row,
    output logic [7:0]  o_avg_red,
    output logic [7:0]  o_avg_green,
    output logic [7:0]  o_avg_blue,
    output logic        o_last_tile
);
    import pta_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    pta_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pta_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_tile_column (o_tile_column),
        .o_tile_row    (o_tile_row),
        .o_avg_red     (o_avg_red),
        .o_avg_green   (o_avg_green),
        .o_avg_blue    (o_avg_blue),
        .o_last_tile   (o_last_tile)
    );

endmodule

[rtl/core/pta_checker.sv]
// Port-level checks for pixelate_tile_average, bound to the top level.
// Depends only on the top-level ports.
module pta_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [9:0] o_tile_column
);

    // a stalled result stays valid and keeps its tile column
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tile_column))
        else $error("result changed while stalled");

    // one pixel at a time: no transaction right after an accepted one
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted on consecutive cycles");

    // an offered result carries a known tile index
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_tile_column))
        else $error("result offered with unknown tile index");

endmodule

bind pixelate_tile_average pta_checker u_pta_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_tile_column (o_tile_column)
);

[verif/pixelate_tile_average_tb.sv]
// Self-checking testbench for pixelate_tile_average: random RGB streams over many
// tile/frame geometries, predicted tile averages checked against the output stream.
// Depends on pta_pkg and the pixelate_tile_average RTL.
module pixelate_tile_average_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pta_pkg::*;

    localparam int CycleLimit = 1_000_000;
    localparam int SettleCycles = 20;

    typedef struct {
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } tile_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [9:0]  o_tile_column;
    logic [9:0]  o_tile_row;
    logic [7:0]  o_avg_red;
    logic [7:0]  o_avg_green;
    logic [7:0]  o_avg_blue;
    logic        o_last_tile;

    pixelate_tile_average dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [6:0]  blk_reg = ResetBlock;
    logic [10:0] wid_reg = ResetWidth;
    logic [10:0] hgt_reg = ResetHeight;
    int unsigned col_red[MaxWidth];
    int unsigned col_green[MaxWidth];
    int unsigned col_blue[MaxWidth];
    int unsigned col_cnt[MaxWidth];
    int unsigned pos_x, pos_y;

    logic [23:0] pix_q[$];
    tile_t       exp_tiles[$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          tiles_seen = 0;
    int          phases = 0;
    int unsigned cycles = 0;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    task automatic restart_frame();
        for (int i = 0; i < MaxWidth; i++) begin
            col_red[i] = 0;
            col_green[i] = 0;
            col_blue[i] = 0;
            col_cnt[i] = 0;
        end
        pos_x = 0;
        pos_y = 0;
    endtask

    task automatic apply_reg_write(logic [1:0] idx, logic [10:0] val);
        case (idx)
            RegBlockSize: begin
                blk_reg = val[6:0];
            end
            RegImageWidth: begin
                wid_reg = val;
            end
            RegImageHeight: begin
                hgt_reg = val;
            end
            default: return;
        endcase
        restart_frame();
    endtask

    task automatic accumulate_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned bs, w, h, tc, tr, ox, oy;
        tile_t t;
        bs = clamp_dim(blk_reg, MaxBlock);
        w = clamp_dim(wid_reg, MaxWidth);
        h = clamp_dim(hgt_reg, MaxHeight);
        tc = pos_x / bs;
        tr = pos_y / bs;
        ox = pos_x - tc * bs;
        oy = pos_y - tr * bs;
        col_red[tc] += r;
        col_green[tc] += g;
        col_blue[tc] += b;
        col_cnt[tc] += 1;
        if ((ox == bs - 1 || pos_x == w - 1) && (oy == bs - 1 || pos_y == h - 1)) begin
            t.col = tc[9:0];
            t.row = tr[9:0];
            t.red = 8'(col_red[tc] / col_cnt[tc]);
            t.green = 8'(col_green[tc] / col_cnt[tc]);
            t.blue = 8'(col_blue[tc] / col_cnt[tc]);
            t.last = (pos_x == w - 1) && (pos_y == h - 1);
            exp_tiles.push_back(t);
            col_red[tc] = 0;
            col_green[tc] = 0;
            col_blue[tc] = 0;
            col_cnt[tc] = 0;
        end
        pos_x++;
        if (pos_x >= w) begin
            pos_x = 0;
            pos_y++;
            if (pos_y >= h) pos_y = 0;
        end
    endtask

    // sender: bursts of random length separated by random gaps
    int          gap_left = 0;
    int          burst_left = 8;
    logic [23:0] next_px;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                accumulate_pixel(i_red, i_green, i_blue);
                pixels_sent++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pix_q.size() > 0) begin
                    next_px = pix_q.pop_front();
                    {i_red, i_green, i_blue} <= next_px;
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern redrawn at random from four modes; one long hold-off on request
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   stall_mode = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles, %0d tiles outstanding", cycles, exp_tiles.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                tiles_seen++;
                if (exp_tiles.size() == 0) begin
                    $error("unexpected tile transaction col=%0d row=%0d", o_tile_column, o_tile_row);
                    errors++;
                end else begin
                    tile_t t;
                    t = exp_tiles.pop_front();
                    if (o_tile_column !== t.col) begin
                        $error("tile_column expected %0d actual %0d", t.col, o_tile_column);
                        errors++;
                    end
                    if (o_tile_row !== t.row) begin
                        $error("tile_row expected %0d actual %0d", t.row, o_tile_row);
                        errors++;
                    end
                    if (o_avg_red !== t.red) begin
                        $error("avg_red expected %0d actual %0d", t.red, o_avg_red);
                        errors++;
                    end
                    if (o_avg_green !== t.green) begin
                        $error("avg_green expected %0d actual %0d", t.green, o_avg_green);
                        errors++;
                    end
                    if (o_avg_blue !== t.blue) begin
                        $error("avg_blue expected %0d actual %0d", t.blue, o_avg_blue);
                        errors++;
                    end
                    if (o_last_tile !== t.last) begin
                        $error("last_tile expected %0d actual %0d", t.last, o_last_tile);
                        errors++;
                    end
                end
            end
            if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
            if (hold_go && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= 600;
                i_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 1) == 0);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pix_q.size() != 0 || i_valid || exp_tiles.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_random(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: pix_q.push_back(24'h000000);
                1: pix_q.push_back(24'hFFFFFF);
                default: pix_q.push_back(24'($urandom));
            endcase
        end
    endtask

    task automatic set_geometry(logic [10:0] bs, logic [10:0] w, logic [10:0] h);
        int order;
        order = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            case ((order + k) % 3)
                0: write_reg(RegBlockSize, bs);
                1: write_reg(RegImageWidth, w);
                default: write_reg(RegImageHeight, h);
            endcase
        end
        phases++;
    endtask

    initial begin
        int w, h, bs, frame, n, random_px;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry, extreme component values
        pix_q.push_back(24'h000000);
        pix_q.push_back(24'hFFFFFF);
        pix_q.push_back(24'hFF00FF);
        pix_q.push_back(24'h00FF00);
        wait_drained();

        // zero block size acts as one: every pixel is a tile, frame wraps
        set_geometry(0, 3, 2);
        pix_q.push_back(24'hFFFFFF);
        pix_q.push_back(24'h000000);
        push_random(8);
        wait_drained();

        // unknown index leaves the frame running
        write_reg(2'd3, 11'h7FF);
        push_random(4);
        wait_drained();

        // single-pixel frame
        set_geometry(1, 1, 1);
        push_random(3);
        wait_drained();

        // oversize values clamp; block 128 masks to zero
        set_geometry(128, 2047, 1);
        push_random(300);
        wait_drained();
        set_geometry(127, 5, 3);
        push_random(16);
        wait_drained();

        // largest tile side, cut at the right border; all white then random
        set_geometry(64, 70, 3);
        for (int i = 0; i < 210; i++) pix_q.push_back(24'hFFFFFF);
        wait_drained();
        set_geometry(64, 70, 3);
        push_random(210);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        set_geometry(1, 16, 16);
        hold_go = 1'b1;
        push_random(300);
        wait_drained();

        random_px = 0;
        while (random_px < 350 || tiles_seen < 200) begin
            bs = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 6);
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 200) : $urandom_range(1, 24);
            h = $urandom_range(0, 12);
            set_geometry(11'(bs), 11'(w), 11'(h));
            frame = clamp_dim(w, MaxWidth) * clamp_dim(h, MaxHeight);
            n = (frame > 600) ? $urandom_range(1, 600) : frame * $urandom_range(1, 2)
                + $urandom_range(0, frame);
            if (phases % 2 == 0) begin
                // sender pauses mid-frame until the output has caught up
                push_random(n / 2);
                wait_drained();
                push_random(n - n / 2);
            end else begin
                push_random(n);
            end
            random_px += n;
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (exp_tiles.size() != 0) begin
            $error("%0d expected tiles never arrived", exp_tiles.size());
            errors++;
        end
        $display("Covered %0d geometries, %0d pixels in, %0d tiles checked, %0d cycles",
                 phases, pixels_sent, tiles_seen, cycles);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
